// ===== hw/rtl/pstb_pkg.sv =====
package pstb_pkg;

    // Sizes of the bank
    localparam int NUM_COUNTERS = 16;
    localparam int NUM_LEVELS   = 3;
    localparam int CFG_LIMITS   = 3;
    localparam int STAGES       = (NUM_LEVELS < CFG_LIMITS) ? NUM_LEVELS : CFG_LIMITS;
    localparam int IDX_W        = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

    // Field widths
    localparam int VAL_W     = 32;
    localparam int LOAD_W    = 31;
    localparam int PS_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 5;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTERS = 3'd4;

    // Counter classes (code 3 behaves as the 32-bit class)
    localparam logic [1:0] CLASS_8  = 2'd0;
    localparam logic [1:0] CLASS_16 = 2'd1;
    localparam logic [1:0] CLASS_32 = 2'd2;
    localparam logic [1:0] CLASS_X  = 2'd3;

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_SET,
        KIND_SET_RUN,
        KIND_SET_LEVEL,
        KIND_RUN,
        KIND_STOP,
        KIND_QUERY,
        KIND_RETRIG
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_ID,
        ERR_LEVEL
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_REPORT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic sweep;
        logic report;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic sweep_last;
    } dp_stat_t;

    function automatic logic [VAL_W-1:0] class_mask(input logic [1:0] c);
        case (c)
            CLASS_8:  class_mask = 32'h0000_00FF;
            CLASS_16: class_mask = 32'h0000_FFFF;
            default:  class_mask = 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] class_max(input logic [1:0] c);
        case (c)
            CLASS_8:  class_max = 32'h0000_007F;
            CLASS_16: class_max = 32'h0000_7FFF;
            default:  class_max = 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic is_neg(input logic [VAL_W-1:0] v, input logic [1:0] c);
        case (c)
            CLASS_8:  is_neg = v[7];
            CLASS_16: is_neg = v[15];
            default:  is_neg = v[31];
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] sign_ext(input logic [VAL_W-1:0] v,
                                                  input logic [1:0] c);
        case (c)
            CLASS_8:  sign_ext = {{24{v[7]}}, v[7:0]};
            CLASS_16: sign_ext = {{16{v[15]}}, v[15:0]};
            default:  sign_ext = v;
        endcase
    endfunction

endpackage

// ===== hw/rtl/pstb_datapath.sv =====
module pstb_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pstb_pkg::ctl_cmd_t                cmd,
    output pstb_pkg::dp_stat_t                stat,
    input  logic [2:0]                        s_kind,
    input  logic [3:0]                        s_counter_id,
    input  logic [pstb_pkg::LOAD_W-1:0]       s_load_value,
    input  logic [1:0]                        s_size_class,
    input  logic [1:0]                        s_level_sel,
    output logic                              m_expired,
    output logic                              m_stopped,
    output logic signed [pstb_pkg::VAL_W-1:0] m_remaining,
    output logic [pstb_pkg::LOAD_W-1:0]       m_elapsed,
    output logic                              m_retrigger_done,
    output logic [1:0]                        m_error_code,
    input  logic                              cfg_we,
    input  logic [pstb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pstb_pkg::CFG_W-1:0]        cfg_wdata
);
    import pstb_pkg::*;

    // Captured command
    kind_t              kind_reg;
    logic [3:0]         id_reg;
    logic [LOAD_W-1:0]  load_reg;
    logic [1:0]         sc_reg;
    logic [1:0]         lsel_reg;

    // Configuration
    logic [PS_W-1:0]    limit_reg [CFG_LIMITS];
    logic [1:0]         lvl_cfg_reg;
    logic [CNT_W-1:0]   cnt_cfg_reg;

    // Prescaler cascade
    logic [PS_W-1:0]    ps_reg [STAGES];
    logic [STAGES:0]    fire_reg;

    // Counter bank
    logic [VAL_W-1:0]   val_reg [NUM_COUNTERS];
    logic               en_reg  [NUM_COUNTERS];
    logic [1:0]         lvl_reg [NUM_COUNTERS];
    logic [1:0]         cls_reg [NUM_COUNTERS];

    logic [IDX_W-1:0]   sweep_idx_reg;
    err_t               err_reg;
    logic               retrig_reg;

    // Result register
    logic               exp_reg;
    logic               stop_reg;
    logic [VAL_W-1:0]   rem_reg;
    logic [LOAD_W-1:0]  ela_reg;
    logic               rtd_reg;
    err_t               code_reg;

    logic [1:0]         act_lvl;
    logic [CNT_W-1:0]   act_cnt;
    logic [IDX_W-1:0]   id_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [VAL_W-1:0]   rd_val;
    logic               rd_en;
    logic [1:0]         rd_lvl;
    logic [1:0]         rd_cls;
    err_t               err_now;
    logic [PS_W-1:0]    ps_work [STAGES+1];
    logic [STAGES:0]    fire_now;
    logic               wr_en;
    logic [VAL_W-1:0]   wr_val;
    logic               wr_run;
    logic [1:0]         wr_lvl;
    logic [1:0]         wr_cls;
    logic               retrig_now;
    logic [VAL_W-1:0]   ev;
    logic [VAL_W-1:0]   rem_now;
    logic [VAL_W-1:0]   ela_now;

    assign act_lvl = (lvl_cfg_reg > 2'(STAGES)) ? 2'(STAGES) : lvl_cfg_reg;
    assign act_cnt = (cnt_cfg_reg > CNT_W'(NUM_COUNTERS)) ? CNT_W'(NUM_COUNTERS)
                                                           : cnt_cfg_reg;

    assign id_idx = IDX_W'(id_reg);
    assign rd_idx = cmd.sweep ? sweep_idx_reg : id_idx;
    assign rd_val = val_reg[rd_idx];
    assign rd_en  = en_reg[rd_idx];
    assign rd_lvl = lvl_reg[rd_idx];
    assign rd_cls = cls_reg[rd_idx];

    assign stat.is_tick    = (kind_reg == KIND_TICK);
    assign stat.sweep_last = (sweep_idx_reg == IDX_W'(NUM_COUNTERS - 1));

    // Level check comes before the id check
    always_comb begin
        err_now = ERR_NONE;
        if (kind_reg != KIND_TICK) begin
            if (kind_reg == KIND_SET_LEVEL && lsel_reg > act_lvl) begin
                err_now = ERR_LEVEL;
            end else if (CNT_W'(id_reg) >= act_cnt) begin
                err_now = ERR_ID;
            end
        end
    end

    // Prescaler cascade for one tick
    always_comb begin
        for (int i = 0; i < STAGES; i++) begin
            ps_work[i] = ps_reg[i];
        end
        ps_work[STAGES] = '0;
        fire_now        = '0;
        fire_now[0]     = 1'b1;
        ps_work[0]      = ps_work[0] + PS_W'(1);
        for (int i = 0; i < STAGES; i++) begin
            if (i < int'(act_lvl) && ps_work[i] >= limit_reg[i]) begin
                fire_now[i+1] = 1'b1;
                ps_work[i]    = '0;
                if (i + 1 < int'(act_lvl)) begin
                    ps_work[i+1] = ps_work[i+1] + PS_W'(1);
                end
            end
        end
    end

    // Entry update: command execution or one sweep step
    always_comb begin
        logic [1:0] sc_eff;
        sc_eff     = (sc_reg == CLASS_X) ? CLASS_32 : sc_reg;
        wr_en      = 1'b0;
        wr_val     = rd_val;
        wr_run     = rd_en;
        wr_lvl     = rd_lvl;
        wr_cls     = rd_cls;
        retrig_now = 1'b0;
        if (cmd.exec && kind_reg != KIND_TICK && err_now == ERR_NONE) begin
            wr_en = 1'b1;
            case (kind_reg) inside
                KIND_SET, KIND_SET_RUN: begin
                    wr_cls = sc_eff;
                    wr_val = (VAL_W'(load_reg) - VAL_W'(1)) & class_mask(sc_eff);
                    if (kind_reg == KIND_SET_RUN) begin
                        wr_run = 1'b1;
                    end
                end
                KIND_SET_LEVEL: wr_lvl = lsel_reg;
                KIND_RUN:       wr_run = 1'b1;
                KIND_STOP:      wr_run = 1'b0;
                KIND_RETRIG: begin
                    if (is_neg(rd_val, rd_cls)) begin
                        wr_val     = (rd_val + class_max(rd_cls)) & class_mask(rd_cls);
                        retrig_now = 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (cmd.sweep) begin
            if (CNT_W'(sweep_idx_reg) < act_cnt && rd_en && fire_reg[rd_lvl]
                && !is_neg(rd_val, rd_cls)) begin
                wr_en  = 1'b1;
                wr_val = (rd_val - VAL_W'(1)) & class_mask(rd_cls);
            end
        end
    end

    // Status of the addressed counter
    assign ev      = sign_ext(rd_val, rd_cls);
    assign rem_now = ev + VAL_W'(1);
    assign ela_now = class_max(rd_cls) - VAL_W'(1) - ev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg[0] <= PS_W'(1);
            limit_reg[1] <= PS_W'(1);
            limit_reg[2] <= PS_W'(1);
            lvl_cfg_reg  <= 2'd3;
            cnt_cfg_reg  <= CNT_W'(16);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LIMIT0:   limit_reg[0] <= cfg_wdata;
                CFG_LIMIT1:   limit_reg[1] <= cfg_wdata;
                CFG_LIMIT2:   limit_reg[2] <= cfg_wdata;
                CFG_LEVELS:   lvl_cfg_reg  <= cfg_wdata[1:0];
                CFG_COUNTERS: cnt_cfg_reg  <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= kind_t'(s_kind);
            id_reg   <= s_counter_id;
            load_reg <= s_load_value;
            sc_reg   <= s_size_class;
            lsel_reg <= s_level_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                ps_reg[i] <= '0;
            end
            fire_reg      <= '0;
            sweep_idx_reg <= '0;
            err_reg       <= ERR_NONE;
            retrig_reg    <= 1'b0;
        end else begin
            if (cmd.exec) begin
                err_reg       <= err_now;
                retrig_reg    <= retrig_now;
                sweep_idx_reg <= '0;
                if (kind_reg == KIND_TICK) begin
                    for (int i = 0; i < STAGES; i++) begin
                        ps_reg[i] <= ps_work[i];
                    end
                    fire_reg <= fire_now;
                end
            end else if (cmd.sweep) begin
                sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                val_reg[i] <= '0;
                en_reg[i]  <= 1'b0;
                lvl_reg[i] <= '0;
                cls_reg[i] <= CLASS_8;
            end
        end else if (wr_en) begin
            val_reg[rd_idx] <= wr_val;
            en_reg[rd_idx]  <= wr_run;
            lvl_reg[rd_idx] <= wr_lvl;
            cls_reg[rd_idx] <= wr_cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.report) begin
            if (kind_reg == KIND_TICK || err_reg != ERR_NONE) begin
                exp_reg  <= 1'b0;
                stop_reg <= 1'b0;
                rem_reg  <= '0;
                ela_reg  <= '0;
                rtd_reg  <= 1'b0;
                code_reg <= err_reg;
            end else begin
                exp_reg  <= is_neg(rd_val, rd_cls);
                stop_reg <= !rd_en;
                rem_reg  <= rem_now;
                ela_reg  <= ela_now[LOAD_W-1:0];
                rtd_reg  <= retrig_reg;
                code_reg <= ERR_NONE;
            end
        end
    end

    assign m_expired        = exp_reg;
    assign m_stopped        = stop_reg;
    assign m_remaining      = signed'(rem_reg);
    assign m_elapsed        = ela_reg;
    assign m_retrigger_done = rtd_reg;
    assign m_error_code     = code_reg;

    a_err_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && err_now != ERR_NONE) |-> !wr_en)
        else $error("rejected command modified a counter");

    a_tick_fires_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && kind_reg == KIND_TICK) |=> fire_reg[0])
        else $error("tick did not fire the base level");

    a_sweep_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sweep && !stat.sweep_last) |=> sweep_idx_reg == $past(sweep_idx_reg) + IDX_W'(1))
        else $error("sweep index skipped");

endmodule

// ===== hw/rtl/pstb_ctrl.sv =====
module pstb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output pstb_pkg::ctl_cmd_t  cmd,
    input  pstb_pkg::dp_stat_t  stat
);
    import pstb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_EXEC;
            ST_EXEC:   state_next = stat.is_tick ? ST_SWEEP : ST_REPORT;
            ST_SWEEP:  if (stat.sweep_last) state_next = ST_REPORT;
            ST_REPORT: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC:   cmd.exec   = 1'b1;
            ST_SWEEP:  cmd.sweep  = 1'b1;
            ST_REPORT: cmd.report = slot_free;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.report) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    a_tick_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && stat.is_tick) |=> state_reg == ST_SWEEP)
        else $error("tick skipped the counter sweep");

    a_report_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |=> (m_valid && state_reg == ST_IDLE))
        else $error("loaded result not presented");

endmodule

// ===== hw/rtl/prescaled_soft_timer_bank.sv =====
// Results: a command's result is loaded into the result register after its execute step;
//   a tick's result after the sweep, which visits one counter per cycle.
// Flow: a new command or tick is taken only after the previous one has been reported;
//   a pending result that is not taken holds the next item in its report step.
// Reset (aresetn, synchronous, active low): all counters zero, stopped, level 0,
//   8-bit class; prescale counts zero; limits 1, levels 3, counters 16.
module prescaled_soft_timer_bank (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Command / tick channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_kind,
    input  logic [3:0]                        s_counter_id,
    input  logic [pstb_pkg::LOAD_W-1:0]       s_load_value,
    input  logic [1:0]                        s_size_class,
    input  logic [1:0]                        s_level_sel,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_expired,
    output logic                              m_stopped,
    output logic signed [pstb_pkg::VAL_W-1:0] m_remaining,
    output logic [pstb_pkg::LOAD_W-1:0]       m_elapsed,
    output logic                              m_retrigger_done,
    output logic [1:0]                        m_error_code,
    // Register write port
    input  logic                              cfg_we,
    input  logic [pstb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pstb_pkg::CFG_W-1:0]        cfg_wdata
);
    import pstb_pkg::*;

    // The controller steps each transfer through capture, execute, an optional
    // sweep over the whole counter bank (ticks only) and a report into the
    // result register. The result register lets a new transfer be taken while
    // the previous result still waits on m_ready.
    ctl_cmd_t cmd;
    dp_stat_t stat;

    pstb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Datapath: register file, prescaler cascade and counter bank.
    // Execute resolves the id/level checks and updates one counter entry, or,
    // for a tick, advances the prescale stages and latches which levels fire.
    // The sweep then decrements each active, enabled, non-negative counter whose level
    // fired, one counter per cycle.
    pstb_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_kind           (s_kind),
        .s_counter_id     (s_counter_id),
        .s_load_value     (s_load_value),
        .s_size_class     (s_size_class),
        .s_level_sel      (s_level_sel),
        .m_expired        (m_expired),
        .m_stopped        (m_stopped),
        .m_remaining      (m_remaining),
        .m_elapsed        (m_elapsed),
        .m_retrigger_done (m_retrigger_done),
        .m_error_code     (m_error_code),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

endmodule
